/* design/aes_pkg.sv */
// ----------------------------------------------------------------------------
// AES package
// S-box table, GF(2^8) helpers and shared types for the AES-128 pipeline.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam logic [7:0]  RedPoly   = 8'h1B;

  // Configuration register indexes
  localparam logic [0:0] RegKeyHigh = 1'b0;
  localparam logic [0:0] RegKeyLow  = 1'b1;

  typedef logic [127:0] block_t;

  // Status word passed between the round stages
  typedef struct packed {
    logic valid;
  } stage_hs_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7C; 8'h02: r=8'h77; 8'h03: r=8'h7B;
      8'h04: r=8'hF2; 8'h05: r=8'h6B; 8'h06: r=8'h6F; 8'h07: r=8'hC5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0A: r=8'h67; 8'h0B: r=8'h2B;
      8'h0C: r=8'hFE; 8'h0D: r=8'hD7; 8'h0E: r=8'hAB; 8'h0F: r=8'h76;
      8'h10: r=8'hCA; 8'h11: r=8'h82; 8'h12: r=8'hC9; 8'h13: r=8'h7D;
      8'h14: r=8'hFA; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hF0;
      8'h18: r=8'hAD; 8'h19: r=8'hD4; 8'h1A: r=8'hA2; 8'h1B: r=8'hAF;
      8'h1C: r=8'h9C; 8'h1D: r=8'hA4; 8'h1E: r=8'h72; 8'h1F: r=8'hC0;
      8'h20: r=8'hB7; 8'h21: r=8'hFD; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3F; 8'h26: r=8'hF7; 8'h27: r=8'hCC;
      8'h28: r=8'h34; 8'h29: r=8'hA5; 8'h2A: r=8'hE5; 8'h2B: r=8'hF1;
      8'h2C: r=8'h71; 8'h2D: r=8'hD8; 8'h2E: r=8'h31; 8'h2F: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hC7; 8'h32: r=8'h23; 8'h33: r=8'hC3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9A;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3A: r=8'h80; 8'h3B: r=8'hE2;
      8'h3C: r=8'hEB; 8'h3D: r=8'h27; 8'h3E: r=8'hB2; 8'h3F: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2C; 8'h43: r=8'h1A;
      8'h44: r=8'h1B; 8'h45: r=8'h6E; 8'h46: r=8'h5A; 8'h47: r=8'hA0;
      8'h48: r=8'h52; 8'h49: r=8'h3B; 8'h4A: r=8'hD6; 8'h4B: r=8'hB3;
      8'h4C: r=8'h29; 8'h4D: r=8'hE3; 8'h4E: r=8'h2F; 8'h4F: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hD1; 8'h52: r=8'h00; 8'h53: r=8'hED;
      8'h54: r=8'h20; 8'h55: r=8'hFC; 8'h56: r=8'hB1; 8'h57: r=8'h5B;
      8'h58: r=8'h6A; 8'h59: r=8'hCB; 8'h5A: r=8'hBE; 8'h5B: r=8'h39;
      8'h5C: r=8'h4A; 8'h5D: r=8'h4C; 8'h5E: r=8'h58; 8'h5F: r=8'hCF;
      8'h60: r=8'hD0; 8'h61: r=8'hEF; 8'h62: r=8'hAA; 8'h63: r=8'hFB;
      8'h64: r=8'h43; 8'h65: r=8'h4D; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hF9; 8'h6A: r=8'h02; 8'h6B: r=8'h7F;
      8'h6C: r=8'h50; 8'h6D: r=8'h3C; 8'h6E: r=8'h9F; 8'h6F: r=8'hA8;
      8'h70: r=8'h51; 8'h71: r=8'hA3; 8'h72: r=8'h40; 8'h73: r=8'h8F;
      8'h74: r=8'h92; 8'h75: r=8'h9D; 8'h76: r=8'h38; 8'h77: r=8'hF5;
      8'h78: r=8'hBC; 8'h79: r=8'hB6; 8'h7A: r=8'hDA; 8'h7B: r=8'h21;
      8'h7C: r=8'h10; 8'h7D: r=8'hFF; 8'h7E: r=8'hF3; 8'h7F: r=8'hD2;
      8'h80: r=8'hCD; 8'h81: r=8'h0C; 8'h82: r=8'h13; 8'h83: r=8'hEC;
      8'h84: r=8'h5F; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hC4; 8'h89: r=8'hA7; 8'h8A: r=8'h7E; 8'h8B: r=8'h3D;
      8'h8C: r=8'h64; 8'h8D: r=8'h5D; 8'h8E: r=8'h19; 8'h8F: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4F; 8'h93: r=8'hDC;
      8'h94: r=8'h22; 8'h95: r=8'h2A; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hEE; 8'h9A: r=8'hB8; 8'h9B: r=8'h14;
      8'h9C: r=8'hDE; 8'h9D: r=8'h5E; 8'h9E: r=8'h0B; 8'h9F: r=8'hDB;
      8'hA0: r=8'hE0; 8'hA1: r=8'h32; 8'hA2: r=8'h3A; 8'hA3: r=8'h0A;
      8'hA4: r=8'h49; 8'hA5: r=8'h06; 8'hA6: r=8'h24; 8'hA7: r=8'h5C;
      8'hA8: r=8'hC2; 8'hA9: r=8'hD3; 8'hAA: r=8'hAC; 8'hAB: r=8'h62;
      8'hAC: r=8'h91; 8'hAD: r=8'h95; 8'hAE: r=8'hE4; 8'hAF: r=8'h79;
      8'hB0: r=8'hE7; 8'hB1: r=8'hC8; 8'hB2: r=8'h37; 8'hB3: r=8'h6D;
      8'hB4: r=8'h8D; 8'hB5: r=8'hD5; 8'hB6: r=8'h4E; 8'hB7: r=8'hA9;
      8'hB8: r=8'h6C; 8'hB9: r=8'h56; 8'hBA: r=8'hF4; 8'hBB: r=8'hEA;
      8'hBC: r=8'h65; 8'hBD: r=8'h7A; 8'hBE: r=8'hAE; 8'hBF: r=8'h08;
      8'hC0: r=8'hBA; 8'hC1: r=8'h78; 8'hC2: r=8'h25; 8'hC3: r=8'h2E;
      8'hC4: r=8'h1C; 8'hC5: r=8'hA6; 8'hC6: r=8'hB4; 8'hC7: r=8'hC6;
      8'hC8: r=8'hE8; 8'hC9: r=8'hDD; 8'hCA: r=8'h74; 8'hCB: r=8'h1F;
      8'hCC: r=8'h4B; 8'hCD: r=8'hBD; 8'hCE: r=8'h8B; 8'hCF: r=8'h8A;
      8'hD0: r=8'h70; 8'hD1: r=8'h3E; 8'hD2: r=8'hB5; 8'hD3: r=8'h66;
      8'hD4: r=8'h48; 8'hD5: r=8'h03; 8'hD6: r=8'hF6; 8'hD7: r=8'h0E;
      8'hD8: r=8'h61; 8'hD9: r=8'h35; 8'hDA: r=8'h57; 8'hDB: r=8'hB9;
      8'hDC: r=8'h86; 8'hDD: r=8'hC1; 8'hDE: r=8'h1D; 8'hDF: r=8'h9E;
      8'hE0: r=8'hE1; 8'hE1: r=8'hF8; 8'hE2: r=8'h98; 8'hE3: r=8'h11;
      8'hE4: r=8'h69; 8'hE5: r=8'hD9; 8'hE6: r=8'h8E; 8'hE7: r=8'h94;
      8'hE8: r=8'h9B; 8'hE9: r=8'h1E; 8'hEA: r=8'h87; 8'hEB: r=8'hE9;
      8'hEC: r=8'hCE; 8'hED: r=8'h55; 8'hEE: r=8'h28; 8'hEF: r=8'hDF;
      8'hF0: r=8'h8C; 8'hF1: r=8'hA1; 8'hF2: r=8'h89; 8'hF3: r=8'h0D;
      8'hF4: r=8'hBF; 8'hF5: r=8'hE6; 8'hF6: r=8'h42; 8'hF7: r=8'h68;
      8'hF8: r=8'h41; 8'hF9: r=8'h99; 8'hFA: r=8'h2D; 8'hFB: r=8'h0F;
      8'hFC: r=8'hB0; 8'hFD: r=8'h54; 8'hFE: r=8'hBB; default: r=8'h16;
    endcase
    return r;
  endfunction

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? RedPoly : 8'h00);
  endfunction

  // SubBytes and ShiftRows
  function automatic block_t sub_shift(input block_t s);
    block_t c;
    for (int col = 0; col < 4; col++) begin
      for (int row = 0; row < 4; row++) begin
        c[127-8*(4*col+row) -: 8] = sbox(s[127-8*(4*((col+row)%4)+row) -: 8]);
      end
    end
    return c;
  endfunction

  // MixColumns
  function automatic block_t mix(input block_t s);
    block_t c;
    logic [7:0] a0, a1, a2, a3, al;
    for (int col = 0; col < 4; col++) begin
      a0 = s[127-32*col -: 8];
      a1 = s[119-32*col -: 8];
      a2 = s[111-32*col -: 8];
      a3 = s[103-32*col -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      c[127-32*col -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      c[119-32*col -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      c[111-32*col -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      c[103-32*col -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return c;
  endfunction

  // One key schedule step: previous round key to next
  function automatic block_t key_next(input block_t k, input logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

/* design/aes_round.sv */
// ----------------------------------------------------------------------------
// AES round stage
// One registered round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey,
// with the next round key computed alongside.
// ----------------------------------------------------------------------------
module aes_round #(
  parameter bit          Final = 1'b0,
  parameter logic [7:0]  Rcon  = 8'h01
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aes_pkg::stage_hs_t up_i,
  output logic              up_ready_o,
  input  aes_pkg::block_t   state_i,
  input  aes_pkg::block_t   key_i,
  output aes_pkg::stage_hs_t dn_o,
  input  logic              dn_ready_i,
  output aes_pkg::block_t   state_o,
  output aes_pkg::block_t   key_o
);
  import aes_pkg::*;

  logic   valid_q;
  block_t state_q, key_q;
  block_t rk, ss;

  assign up_ready_o = !valid_q || dn_ready_i;

  // compute round key and round output
  always_comb begin
    rk = key_next(key_i, Rcon);
    ss = sub_shift(state_i);
    if (!Final) begin
      ss = mix(ss);
    end
  end

  // hold valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_i.valid;
    end
  end

  // advance payload
  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_i.valid) begin
      state_q <= ss ^ rk;
      key_q   <= rk;
    end
  end

  assign dn_o.valid = valid_q;
  assign state_o    = state_q;
  assign key_o      = key_q;

endmodule

/* design/aes128_block_encrypt_unit.sv */
// Pipeline: one entry stage plus ten round stages, each a register, lie between
// input acceptance and result valid.
// Throughput: one block per cycle while out_ready_i is high; the entry and ten round stages are the pipeline.
// Reset: asynchronous active low; clears valid bits and sets the key to zero.
// ----------------------------------------------------------------------------
// AES-128 encryption unit
// Fully pipelined AES-128 cipher with on-the-fly round key expansion.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] pt_high_i,
  input  logic [63:0] pt_low_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] ct_high_o,
  output logic [63:0] ct_low_o
);
  import aes_pkg::*;

  localparam logic [7:0] RconTab [NumRounds] =
    '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36};

  logic [63:0] key_hi_q, key_lo_q;
  block_t      key;

  stage_hs_t hs   [NumRounds+1];
  logic      rdy  [NumRounds+2];
  block_t    st   [NumRounds+1];
  block_t    ks   [NumRounds+1];

  logic   v0_q;
  block_t st0_q, k0_q;

  assign cfg_ready_o = 1'b1;
  assign key = {key_hi_q, key_lo_q};

  // write key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegKeyHigh: key_hi_q <= cfg_data_i;
        RegKeyLow:  key_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // entry stage: initial AddRoundKey
  assign rdy[0] = !v0_q || rdy[1];
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (rdy[0]) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      st0_q <= {pt_high_i, pt_low_i} ^ key;
      k0_q  <= key;
    end
  end

  assign hs[0].valid = v0_q;
  assign st[0] = st0_q;
  assign ks[0] = k0_q;

  // round stages
  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    aes_round #(
      .Final (r == NumRounds - 1),
      .Rcon  (RconTab[r])
    ) u_round (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_i       (hs[r]),
      .up_ready_o (rdy[r+1]),
      .state_i    (st[r]),
      .key_i      (ks[r]),
      .dn_o       (hs[r+1]),
      .dn_ready_i (rdy[r+2]),
      .state_o    (st[r+1]),
      .key_o      (ks[r+1])
    );
  end

  assign rdy[NumRounds+1] = out_ready_i;
  assign out_valid_o = hs[NumRounds].valid;
  assign ct_high_o   = st[NumRounds][127:64];
  assign ct_low_o    = st[NumRounds][63:0];

endmodule

/* design/aes128_block_encrypt_checker.sv */
// ----------------------------------------------------------------------------
// AES-128 port checker
// Watches the top-level ports for handshake and pipeline depth rules.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] ct_high_o,
  input logic        cfg_ready_o
);

  // hold result word while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ct_high_o))
    else $error("result word changed under stall");

  // nothing comes out without something having gone in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(in_valid_i, 11) && !$past(out_valid_o) |-> !out_valid_o)
    else $error("result word without input");

  // an empty or draining pipe takes input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

  // key port never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config port stalled");

endmodule

bind aes128_block_encrypt_unit aes128_block_encrypt_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .ct_high_o   (ct_high_o),
  .cfg_ready_o (cfg_ready_o)
);
